FILE: hw/rtl/random_draw_without_replacement_core_macros.svh
// Assertion helpers for the sampler RTL.
`ifndef RANDOM_DRAW_WITHOUT_REPLACEMENT_CORE_MACROS_SVH
`define RANDOM_DRAW_WITHOUT_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sampler check failed");

// Next-cycle implication, checked outside reset.
`define RDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sampler check failed");

`endif

FILE: hw/rtl/rdw_pkg.sv
package rdw_pkg;

    localparam int VALUE_W = 32;
    localparam int TYPE_W  = 2;
    localparam int RAND_W  = 16;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_entry;

endpackage

FILE: hw/rtl/rdw_store.sv
module rdw_store
    import rdw_pkg::*;
#(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  t_entry        i_wdata,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single port: one address per cycle, with an optional write and a registered read of the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/random_draw_without_replacement_core.sv
// Urn sampler. Load requests (mode 0) append a tagged 32-bit element to a list of up to
// MAX_ITEMS entries; elements past capacity are dropped, and last_item closes the list.
// A draw request (mode 1, or a closing load with draw_after_load) picks entry
// (random_word * pool) >> 16 of the remaining pool, returns it, and swaps it with the last
// pool entry so the pool shrinks by one. An exhausted pool is refilled to the full list and
// the result carries pool_refilled. A draw with no elements loaded returns nothing.
// Each request walks the sequencer states: a load runs through S_LOAD, a draw through S_CALC,
// S_PICK, S_RDLAST, S_WR1 and S_WR2, a closing load with draw through S_LOAD and then the
// draw states, and a draw on an empty list through S_CALC alone; busy is high in all of them.
// The single store port serves the swap's two reads and two writes in turn. A new request
// is taken only when start is high and busy is low. A result is shown for exactly one
// cycle with o_valid high, in the last busy cycle of its request, and cannot be held off:
// the receiver must take it in that cycle.
`include "random_draw_without_replacement_core_macros.svh"

module random_draw_without_replacement_core
    import rdw_pkg::*;
#(
    parameter int MAX_ITEMS = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [VALUE_W-1:0] i_item_value,
    input  logic [TYPE_W-1:0] i_item_type,
    input  logic              i_last_item,
    input  logic              i_draw_after_load,
    input  logic [RAND_W-1:0] i_random_word,
    output logic              o_valid,
    output logic [VALUE_W-1:0] o_out_value,
    output logic [TYPE_W-1:0] o_out_type,
    output logic              o_pool_refilled
);

    // Counts must hold MAX_ITEMS itself; addresses only reach MAX_ITEMS-1.
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int PW = RAND_W + CW;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_RDLAST = 3'd4;
    localparam logic [2:0] S_WR1    = 3'd5;
    localparam logic [2:0] S_WR2    = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_list_count, n_list_count;
    logic [CW-1:0]      r_pool_left, n_pool_left;
    logic [CW-1:0]      r_write_index, n_write_index;

    // Latched request fields.
    t_entry             r_item;
    logic               r_last;
    logic               r_dal;
    logic [RAND_W-1:0]  r_rnd;

    // Draw working registers.
    logic [CW-1:0]      r_pool;
    logic               r_refill;
    logic [PW-1:0]      r_prod;
    logic [CW-1:0]      r_pick;
    t_entry             r_chosen;

    // Result registers.
    logic               r_out_valid;
    t_entry             r_out_item;
    logic               r_out_refill;

    // Store port.
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;

    logic               accept;
    logic [CW-1:0]      pool_sel;
    logic               refill_sel;
    logic [CW-1:0]      last_pos;
    logic               do_swap;
    logic               has_room;

    assign accept   = start && (r_state == S_IDLE);
    assign has_room = r_write_index < MAX_C;
    assign last_pos = r_pool - ONE_C;
    assign do_swap  = r_pick < last_pos;

    // Restart the pool when it is empty or stale.
    always_comb begin
        if ((r_pool_left == '0) || (r_pool_left > r_list_count)) begin
            pool_sel   = r_list_count;
            refill_sel = 1'b1;
        end else begin
            pool_sel   = r_pool_left;
            refill_sel = 1'b0;
        end
    end

    rdw_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Store port mux: one access per sequencer step.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pick[AW-1:0];
        mem_wdata = r_item;
        unique case (r_state)
            S_LOAD: begin
                mem_we    = has_room;
                mem_addr  = r_write_index[AW-1:0];
                mem_wdata = r_item;
            end
            S_PICK: begin
                mem_addr = r_prod[RAND_W +: AW];
            end
            S_RDLAST: begin
                mem_addr = last_pos[AW-1:0];
            end
            S_WR1: begin
                // Move the last pool entry into the chosen slot.
                mem_we    = do_swap;
                mem_addr  = r_pick[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_WR2: begin
                // Park the chosen entry past the shrunken pool.
                mem_we    = do_swap;
                mem_addr  = last_pos[AW-1:0];
                mem_wdata = r_chosen;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer and count updates.
    always_comb begin
        n_state       = r_state;
        n_list_count  = r_list_count;
        n_pool_left   = r_pool_left;
        n_write_index = r_write_index;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_mode ? S_CALC : S_LOAD;
                end
            end
            S_LOAD: begin
                // Drop the element when the list is full; counts stay at capacity.
                if (has_room) begin
                    n_list_count = r_write_index + ONE_C;
                    n_pool_left  = r_write_index + ONE_C;
                end else begin
                    n_list_count = r_write_index;
                    n_pool_left  = r_write_index;
                end
                if (has_room && !r_last) begin
                    n_write_index = r_write_index + ONE_C;
                end
                if (r_last) begin
                    n_write_index = '0;
                end
                n_state = (r_last && r_dal) ? S_CALC : S_IDLE;
            end
            S_CALC: begin
                n_state = (r_list_count == '0) ? S_IDLE : S_PICK;
            end
            S_PICK: begin
                n_state = S_RDLAST;
            end
            S_RDLAST: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                n_pool_left = last_pos;
                n_state     = S_WR2;
            end
            S_WR2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_list_count  <= '0;
            r_pool_left   <= '0;
            r_write_index <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_list_count  <= n_list_count;
            r_pool_left   <= n_pool_left;
            r_write_index <= n_write_index;
            r_out_valid   <= (r_state == S_WR1);
        end
    end

    // Payload and working registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.value <= i_item_value;
            r_item.kind  <= i_item_type;
            r_last       <= i_last_item;
            r_dal        <= i_draw_after_load;
            r_rnd        <= i_random_word;
        end
        if (r_state == S_CALC) begin
            r_pool   <= pool_sel;
            r_refill <= refill_sel;
            // A pool of one always yields slot zero.
            if (pool_sel > ONE_C) begin
                r_prod <= PW'(r_rnd) * PW'(pool_sel);
            end else begin
                r_prod <= '0;
            end
        end
        if (r_state == S_PICK) begin
            r_pick <= r_prod[PW-1:RAND_W];
        end
        if (r_state == S_RDLAST) begin
            r_chosen <= mem_rdata;
        end
        if (r_state == S_WR1) begin
            r_out_item   <= r_chosen;
            r_out_refill <= r_refill;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_out_value     = r_out_item.value;
    assign o_out_type      = r_out_item.kind;
    assign o_pool_refilled = r_out_refill;

    // Results only appear while a request is in flight, one per draw.
    `RDW_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `RDW_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_valid, !o_valid)
    // The pool never exceeds the loaded list.
    `RDW_ASSERT_NOW(a_pool_in_list, i_clk, i_rst_n, 1'b1, r_pool_left <= r_list_count)
    // An accepted request always occupies the block.
    `RDW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

endmodule

FILE: sim/testbench.sv
module testbench;
    import rdw_pkg::*;

    // Size the store as the block does by default; the overflow list needs to run past it.
    localparam int MAX_ITEMS   = 255;
    localparam int N_ITEMS     = 1450;
    // Quiet cycles (no request taken, no result shown) before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching after the last expected draw has come back.
    localparam int TAIL_CYCLES = 16;

    typedef enum bit {
        MODE_LOAD = 1'b0,
        MODE_DRAW = 1'b1
    } t_mode;

    typedef enum bit [TYPE_W-1:0] {
        KIND_INT    = 2'd0,
        KIND_FLOAT  = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    // One request as the driver presents it.
    typedef struct {
        t_mode              mode;
        bit [VALUE_W-1:0]   value;
        bit [TYPE_W-1:0]    kind;
        bit                 last;
        bit                 draw;
        bit [RAND_W-1:0]    rnd;
    } t_urn_req;

    // One drawn element as the block should report it.
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [TYPE_W-1:0]  kind;
        logic               refilled;
    } t_drawn;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = 1'b0;
    logic [VALUE_W-1:0] i_item_value = '0;
    logic [TYPE_W-1:0]  i_item_type = '0;
    logic               i_last_item = 1'b0;
    logic               i_draw_after_load = 1'b0;
    logic [RAND_W-1:0]  i_random_word = '0;
    logic               o_valid;
    logic [VALUE_W-1:0] o_out_value;
    logic [TYPE_W-1:0]  o_out_type;
    logic               o_pool_refilled;

    random_draw_without_replacement_core #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_item_value     (i_item_value),
        .i_item_type      (i_item_type),
        .i_last_item      (i_last_item),
        .i_draw_after_load(i_draw_after_load),
        .i_random_word    (i_random_word),
        .o_valid          (o_valid),
        .o_out_value      (o_out_value),
        .o_out_type       (o_out_type),
        .o_pool_refilled  (o_pool_refilled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Urn predictor: its own copy of the store, the list length, the pool
    // that is left and the slot for the next load.
    // ------------------------------------------------------------------
    t_entry      urn_store [MAX_ITEMS];
    int unsigned urn_len   = 0;
    int unsigned urn_pool  = 0;
    int unsigned urn_wr    = 0;

    t_urn_req    pending_reqs [$];
    t_drawn      expected_draws [$];
    t_urn_req    cur_req;
    int          n_accepted = 0;
    int          n_mismatch = 0;
    int          gap_left   = 0;

    // Pick one element of the pool, queue it as expected and set it aside
    // by swapping it with the last pool entry.
    task automatic urn_draw(input bit [RAND_W-1:0] rnd);
        int unsigned pool;
        int unsigned pick;
        bit          refill;
        t_entry      chosen;
        t_drawn      res;
        // An empty list gives nothing and leaves the state alone.
        if (urn_len == 0) return;
        pool   = urn_pool;
        refill = 1'b0;
        // Refill an exhausted pool to the whole list and flag it.
        if (pool == 0 || pool > urn_len) begin
            pool   = urn_len;
            refill = 1'b1;
        end
        // A pool of one ignores the random word.
        pick = (pool > 1) ? ((32'(rnd) * pool) >> RAND_W) : 0;
        if (pick >= pool) pick = pool - 1;
        chosen       = urn_store[pick];
        res.value    = chosen.value;
        res.kind     = chosen.kind;
        res.refilled = refill;
        expected_draws.push_back(res);
        pool = pool - 1;
        if (pick < pool) begin
            urn_store[pick] = urn_store[pool];
            urn_store[pool] = chosen;
        end
        urn_pool = pool;
    endtask

    // Advance the predictor by one accepted request.
    task automatic predict_request(input t_urn_req r);
        if (r.mode == MODE_DRAW) begin
            urn_draw(r.rnd);
        end else begin
            // Drop the element once the store is full, but still honor last_item.
            if (urn_wr < MAX_ITEMS) begin
                urn_store[urn_wr].value = r.value;
                urn_store[urn_wr].kind  = r.kind;
                urn_wr = urn_wr + 1;
            end
            urn_len  = urn_wr;
            urn_pool = urn_len;
            if (r.last) begin
                urn_wr = 0;
                // draw_after_load only counts on the closing element.
                if (r.draw) urn_draw(r.rnd);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_load(input bit [VALUE_W-1:0] value, input bit [TYPE_W-1:0] kind,
                             input bit last, input bit draw, input bit [RAND_W-1:0] rnd);
        t_urn_req r;
        r.mode  = MODE_LOAD;
        r.value = value;
        r.kind  = kind;
        r.last  = last;
        r.draw  = draw;
        r.rnd   = rnd;
        pending_reqs.push_back(r);
    endtask

    // Fill the unused fields of a draw with noise; the block must ignore them.
    task automatic push_draw(input bit [RAND_W-1:0] rnd);
        t_urn_req r;
        r.mode  = MODE_DRAW;
        r.value = $urandom;
        r.kind  = TYPE_W'($urandom_range(0, 3));
        r.last  = 1'($urandom_range(0, 1));
        r.draw  = 1'($urandom_range(0, 1));
        r.rnd   = rnd;
        pending_reqs.push_back(r);
    endtask

    // Lean on the extremes of the random word now and then.
    function automatic bit [RAND_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic bit [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present one request at a time and hold it until taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit accepted;
        bit idle_ok;
        accepted = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (accepted) begin
                predict_request(cur_req);
                n_accepted = n_accepted + 1;
            end
            // Hold a request that is still waiting; otherwise choose the next step.
            if (!start || accepted) begin
                // Keep a long stretch in the middle free of gaps.
                idle_ok = (n_accepted < 500) || (n_accepted > 900);
                if (gap_left == 0 && pending_reqs.size() != 0 && idle_ok &&
                    $urandom_range(0, 99) < 9) begin
                    gap_left = 1;
                end
                if (gap_left == 0 && pending_reqs.size() != 0) begin
                    cur_req           = pending_reqs.pop_front();
                    start             <= 1'b1;
                    i_mode            <= cur_req.mode;
                    i_item_value      <= cur_req.value;
                    i_item_type       <= cur_req.kind;
                    i_last_item       <= cur_req.last;
                    i_draw_after_load <= cur_req.draw;
                    i_random_word     <= cur_req.rnd;
                end else begin
                    if (gap_left > 0) gap_left = gap_left - 1;
                    // Drop start and toggle the payload so idle inputs are really ignored.
                    start             <= 1'b0;
                    i_mode            <= 1'($urandom_range(0, 1));
                    i_item_value      <= $urandom;
                    i_item_type       <= TYPE_W'($urandom_range(0, 3));
                    i_last_item       <= 1'($urandom_range(0, 1));
                    i_draw_after_load <= 1'($urandom_range(0, 1));
                    i_random_word     <= RAND_W'($urandom_range(0, 65535));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed result must match the oldest expected draw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_drawn want;
        if (i_rst_n && o_valid) begin
            if (expected_draws.size() == 0) begin
                n_mismatch = n_mismatch + 1;
                if (n_mismatch <= 10)
                    $display("tb: unexpected result value=%h kind=%h refilled=%b",
                             o_out_value, o_out_type, o_pool_refilled);
            end else begin
                want = expected_draws.pop_front();
                if (o_out_value !== want.value || o_out_type !== want.kind ||
                    o_pool_refilled !== want.refilled) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("tb: mismatch exp value=%h kind=%h refilled=%b, got %h %h %b",
                                 want.value, want.kind, want.refilled,
                                 o_out_value, o_out_type, o_pool_refilled);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end a run in which nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int  len;
        int  ndraw;
        bit  close;
        bit  is_last;
        bit  overflow_done;
        int  n_total;

        // Directed: draw on an empty list first.
        push_draw('1);
        // One-element list closed with a draw: pool of one, random word unused.
        push_load('0, KIND_INT, 1'b1, 1'b1, 16'h1234);
        // Pool is used up: the next draw refills it.
        push_draw('1);
        // Open a list; draw_after_load without last_item is ignored. Kind 3 kept as is.
        push_load('1, KIND_RSVD, 1'b0, 1'b1, '1);
        push_load(32'ha5a5_a5a5, KIND_FLOAT, 1'b0, 1'b0, '0);
        // Draw in the middle of a list: top and bottom of the random word.
        push_draw('1);
        push_draw('0);
        push_draw(16'h8000);
        // Keep loading the same list, then close it without a draw.
        push_load(32'h5a5a_5a5a, KIND_SYMBOL, 1'b0, 1'b0, '0);
        push_load(32'h0000_0001, KIND_INT, 1'b1, 1'b0, '1);
        push_draw('0);
        push_draw('1);
        push_draw(16'h8000);
        push_draw(16'h7fff);
        push_draw('0);
        // A longer list closed with a draw at the top of the random word.
        push_load(32'h8000_0000, KIND_FLOAT, 1'b0, 1'b0, '0);
        push_load(32'h7fff_ffff, KIND_SYMBOL, 1'b0, 1'b1, '0);
        push_load(32'hdead_beef, KIND_RSVD, 1'b0, 1'b0, '1);
        push_load(32'h0123_4567, KIND_INT, 1'b1, 1'b1, '1);
        push_draw('0);
        push_draw('0);
        push_draw('0);
        push_draw('0);

        // Random: mostly well-formed lists followed by draws, some noise and open lists.
        overflow_done = 1'b0;
        while (pending_reqs.size() < N_ITEMS) begin
            if (!overflow_done && pending_reqs.size() > 400) begin
                // Run past capacity once to see elements dropped.
                len           = $urandom_range(256, 262);
                overflow_done = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                len = $urandom_range(17, 60);
            end else begin
                len = $urandom_range(1, 12);
            end
            close = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++) begin
                is_last = close && (i == len - 1);
                push_load(rand_value(), TYPE_W'($urandom_range(0, 3)), is_last,
                          1'($urandom_range(0, 1)), rand_word());
                if (!is_last && $urandom_range(0, 15) == 0) push_draw(rand_word());
            end
            // Draw enough to wrap the pool and see refills on small lists.
            ndraw = (len > 16) ? $urandom_range(0, 20) : $urandom_range(0, 2 * len + 2);
            for (int i = 0; i < ndraw; i++) push_draw(rand_word());
            // Noise: a request with every field random.
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_draw(rand_word());
                else
                    push_load($urandom, TYPE_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              RAND_W'($urandom_range(0, 65535)));
            end
        end
        n_total = pending_reqs.size();

        // Hold reset, then release it at a rising edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait on the falling edge so the driver's updates have settled.
        while (n_accepted < n_total || expected_draws.size() != 0 || busy)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && expected_draws.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
